@@ rtl/vtd_pkg.sv @@
`timescale 1ns / 1ps

package vtd_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int REF_W       = 16;
  localparam int SLOT_W      = 10;
  localparam int TRIPLE_W    = 3 * REF_W;

  typedef struct packed {
    logic [REF_W-1:0] position_ref;
    logic [REF_W-1:0] texcoord_ref;
    logic [REF_W-1:0] normal_ref;
    logic             last_corner;
  } in_beat_t;

  typedef struct packed {
    logic [SLOT_W-1:0] vertex_slot;
    logic              is_new;
    logic              overflow;
    logic              end_of_mesh;
  } out_beat_t;

  // Port requests from the sequencer to the triple table
  typedef struct packed {
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [TRIPLE_W-1:0] wr_data;
  } tbl_req_t;

endpackage

@@ rtl/vtd_table.sv @@
`timescale 1ns / 1ps

module vtd_table (
  input  logic                         clk,
  input  vtd_pkg::tbl_req_t            req,
  output logic [vtd_pkg::TRIPLE_W-1:0] rdata
);

  logic [vtd_pkg::TRIPLE_W-1:0] mem [vtd_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata <= mem[req.rd_addr];
    end
  end

endmodule

@@ rtl/vtd_seq.sv @@
`timescale 1ns / 1ps

module vtd_seq (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  vtd_pkg::in_beat_t            in_data,
  input  logic                         out_free,
  output logic                         res_valid,
  output vtd_pkg::out_beat_t           res,
  output vtd_pkg::tbl_req_t            req,
  input  logic [vtd_pkg::TRIPLE_W-1:0] rdata
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                       state, state_next;
  logic [vtd_pkg::CNT_W-1:0]    count, count_next;
  logic [vtd_pkg::CNT_W-1:0]    rd_idx, rd_idx_next;
  logic                         pend, pend_next;
  logic [vtd_pkg::IDX_W-1:0]    pend_idx, pend_idx_next;
  logic [vtd_pkg::TRIPLE_W-1:0] key, key_next;
  logic                         last, last_next;
  vtd_pkg::out_beat_t           res_next;
  logic                         hit;

  assign in_ready = (state == S_IDLE);
  assign hit      = pend && (rdata == key);

  always_comb begin
    state_next    = state;
    count_next    = count;
    rd_idx_next   = rd_idx;
    pend_next     = pend;
    pend_idx_next = pend_idx;
    key_next      = key;
    last_next     = last;
    res_next      = res;
    res_valid     = 1'b0;
    req           = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          key_next    = {in_data.position_ref, in_data.texcoord_ref, in_data.normal_ref};
          last_next   = in_data.last_corner;
          rd_idx_next = '0;
          pend_next   = 1'b0;
          state_next  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          res_next.vertex_slot = vtd_pkg::SLOT_W'(pend_idx);
          res_next.is_new      = 1'b0;
          res_next.overflow    = 1'b0;
          res_next.end_of_mesh = last;
          count_next           = last ? '0 : count;
          pend_next            = 1'b0;
          state_next           = S_DONE;
        end else if (!pend && (rd_idx == count)) begin
          // scan exhausted: append if room, else flag overflow
          res_next.end_of_mesh = last;
          if (count < vtd_pkg::CNT_W'(vtd_pkg::TABLE_DEPTH)) begin
            req.wr_en            = 1'b1;
            req.wr_addr          = count[vtd_pkg::IDX_W-1:0];
            req.wr_data          = key;
            res_next.vertex_slot = vtd_pkg::SLOT_W'(count);
            res_next.is_new      = 1'b1;
            res_next.overflow    = 1'b0;
            count_next           = last ? '0 : count + vtd_pkg::CNT_W'(1);
          end else begin
            res_next.vertex_slot = '0;
            res_next.is_new      = 1'b0;
            res_next.overflow    = 1'b1;
            count_next           = last ? '0 : count;
          end
          state_next = S_DONE;
        end else if (rd_idx < count) begin
          req.rd_en     = 1'b1;
          req.rd_addr   = rd_idx[vtd_pkg::IDX_W-1:0];
          rd_idx_next   = rd_idx + vtd_pkg::CNT_W'(1);
          pend_next     = 1'b1;
          pend_idx_next = rd_idx[vtd_pkg::IDX_W-1:0];
        end else begin
          pend_next = 1'b0;
        end
      end
      S_DONE: begin
        // hold the result until the output register frees up
        res_valid = out_free;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx   <= rd_idx_next;
    pend_idx <= pend_idx_next;
    key      <= key_next;
    last     <= last_next;
    res      <= res_next;
  end

endmodule

@@ rtl/vertex_triple_deduplicator.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_data  (vtd_pkg::in_beat_t)
// out      output     out_valid / out_ready  out_data (vtd_pkg::out_beat_t)
//
// A hit ends the scan at the matching entry; a miss reads every stored entry first.
// The scan reads one table entry per cycle and checks it in the next cycle, once the
// table has registered it, in a single 48-bit compare; the next corner is taken in
// the cycle after the result is loaded.
// rst is synchronous and empties the table at once; table contents need no clearing.
// A result waits in the output register; a new corner is taken while it waits,
// and the sequencer holds a finished result until that register frees up.

module vertex_triple_deduplicator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  vtd_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output vtd_pkg::out_beat_t out_data
);

  vtd_pkg::tbl_req_t            req;
  logic [vtd_pkg::TRIPLE_W-1:0] rdata;
  vtd_pkg::out_beat_t           res;
  logic                         res_valid;
  logic                         out_free;

  assign out_free = !out_valid || out_ready;

  vtd_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .req       (req),
    .rdata     (rdata)
  );

  vtd_table u_table (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data <= res;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!out_valid || out_ready))
    else $error("result loaded over a beat not yet taken");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready high right after a corner was accepted");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.is_new && out_data.overflow))
    else $error("new and overflow flagged together");

  a_overflow_slot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.overflow) |-> (out_data.vertex_slot == '0))
    else $error("overflow beat with nonzero slot");

endmodule
